/* sv/mf3_pkg.sv */
package mf3_pkg;

  localparam int MF3_MAX_LINE = 1024;
  localparam int MF3_MAX_HEIGHT = 1024;
  localparam int CFG_W = 11;
  localparam int PIX_W = 8;
  localparam int POS_W = 10;
  localparam int FIFO_DEPTH = 4;

  localparam logic [0:0] REG_LINE_LENGTH = 1'b0;
  localparam logic [0:0] REG_LINE_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] LINE_LENGTH_RESET = 11'd640;
  localparam logic [CFG_W-1:0] LINE_COUNT_RESET = 11'd480;
  localparam logic [CFG_W-1:0] DIM_MIN = 11'd3;

  // One pixel on its way from the line stores to the window.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic             emit;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
  } mf3_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] hi;
  } mf3_trio_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] lim);
    logic [CFG_W-1:0] r;
    r = v;
    if (r < DIM_MIN) r = DIM_MIN;
    if (r > lim) r = lim;
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max8(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic mf3_trio_t sort3(input logic [PIX_W-1:0] a,
                                      input logic [PIX_W-1:0] b,
                                      input logic [PIX_W-1:0] c);
    mf3_trio_t t;
    t.lo = min8(min8(a, b), c);
    t.hi = max8(max8(a, b), c);
    t.md = max8(min8(a, b), min8(max8(a, b), c));
    return t;
  endfunction

endpackage

/* sv/mf3_front.sv */
module mf3_front #(
  parameter int MAX_LINE = mf3_pkg::MF3_MAX_LINE
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mf3_pkg::PIX_W-1:0]      intensity,
  input  logic                           frame_start,
  input  logic [mf3_pkg::CFG_W-1:0]      width,
  input  logic [mf3_pkg::CFG_W-1:0]      height,
  output logic                           push_valid,
  input  logic                           push_ready,
  output mf3_pkg::mf3_item_t             push_item
);
  import mf3_pkg::*;

  localparam int LIM = (MAX_LINE < 1024) ? MAX_LINE : 1024;
  localparam int AW = $clog2(LIM);

  logic [PIX_W-1:0] store_upper [LIM];
  logic [PIX_W-1:0] store_middle [LIM];

  logic [POS_W-1:0] col, row;
  logic [POS_W-1:0] col_next, row_next;
  logic [POS_W-1:0] c0, r0, c1, r1, r2;
  logic [CFG_W-1:0] cn, rn;
  logic             emit, last;
  logic [AW-1:0]    addr;
  logic             accept;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pix;
  logic             s1_emit, s1_last;
  logic [POS_W-1:0] s1_col, s1_row;
  logic [AW-1:0]    s1_addr;
  logic [PIX_W-1:0] rd_up, rd_mid;
  logic             byp;
  logic [PIX_W-1:0] byp_up, byp_mid;
  logic [PIX_W-1:0] s1_up_r, s1_mid_r;
  logic             wr_pend;

  assign accept = in_valid && in_ready;
  assign in_ready = !s1_valid || push_ready;

  // Position of the incoming pixel and of the one after it.
  always_comb begin
    c0 = frame_start ? '0 : col;
    r0 = frame_start ? '0 : row;
    if ({1'b0, c0} >= width) begin
      c1 = '0;
      r1 = r0 + 10'd1;
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = ({1'b0, r1} >= height) ? '0 : r1;
    emit = (r2 >= 10'd2) && (c1 >= 10'd2);
    last = ({1'b0, c1} == width - 11'd1) && ({1'b0, r2} == height - 11'd1);
    cn = {1'b0, c1} + 11'd1;
    rn = {1'b0, r2};
    if (cn >= width) begin
      cn = '0;
      rn = rn + 11'd1;
      if (rn >= height) rn = '0;
    end
    col_next = cn[POS_W-1:0];
    row_next = rn[POS_W-1:0];
    addr = c1[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      s1_valid <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= accept;
      if (accept) begin
        col <= col_next;
        row <= row_next;
        s1_valid <= 1'b1;
      end else if (push_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // The upper store takes the old middle value, known only after the read,
  // so each item writes back in the cycle after it was accepted.
  assign s1_up_r = byp ? byp_up : rd_up;
  assign s1_mid_r = byp ? byp_mid : rd_mid;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_up <= store_upper[addr];
      rd_mid <= store_middle[addr];
      byp <= wr_pend && (s1_addr == addr);
      byp_up <= s1_mid_r;
      byp_mid <= s1_pix;
      s1_pix <= intensity;
      s1_emit <= emit;
      s1_last <= last;
      s1_col <= c1 - 10'd1;
      s1_row <= r2 - 10'd1;
      s1_addr <= addr;
    end
    if (wr_pend) begin
      store_upper[s1_addr] <= s1_mid_r;
      store_middle[s1_addr] <= s1_pix;
    end
  end

  assign push_valid = s1_valid;
  assign push_item.pix = s1_pix;
  assign push_item.up = s1_up_r;
  assign push_item.mid = s1_mid_r;
  assign push_item.emit = s1_emit;
  assign push_item.col = s1_col;
  assign push_item.row = s1_row;
  assign push_item.last = s1_last;

endmodule

/* sv/mf3_fifo.sv */
module mf3_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  mf3_pkg::mf3_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output mf3_pkg::mf3_item_t pop_item
);
  import mf3_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  mf3_item_t       slots [FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign push_ready = (count != CW'(FIFO_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

/* sv/mf3_back.sv */
module mf3_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  mf3_pkg::mf3_item_t         pop_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mf3_pkg::PIX_W-1:0]  median,
  output logic [mf3_pkg::POS_W-1:0]  center_col,
  output logic [mf3_pkg::POS_W-1:0]  center_row,
  output logic                       frame_last
);
  import mf3_pkg::*;

  logic [PIX_W-1:0] win [9];
  logic [PIX_W-1:0] shifted [9];
  logic             en, take;

  logic             p1_valid;
  mf3_trio_t        p1_rows [3];
  logic [POS_W-1:0] p1_col, p1_row;
  logic             p1_last;

  logic             p2_valid;
  logic [PIX_W-1:0] p2_lo, p2_md, p2_hi;
  logic [POS_W-1:0] p2_col, p2_row;
  logic             p2_last;

  mf3_trio_t        md_trio, fin_trio;

  // The pipeline advances whenever the output can move, the window on each take.
  assign en = !out_valid || out_ready;
  assign pop_ready = en;
  assign take = pop_valid && en;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      shifted[k*3+0] = win[k*3+1];
      shifted[k*3+1] = win[k*3+2];
    end
    shifted[2] = pop_item.up;
    shifted[5] = pop_item.mid;
    shifted[8] = pop_item.pix;
  end

  assign md_trio = sort3(p1_rows[0].md, p1_rows[1].md, p1_rows[2].md);
  assign fin_trio = sort3(p2_lo, p2_md, p2_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        for (int i = 0; i < 9; i++) win[i] <= shifted[i];
      end
      if (en) begin
        p1_valid <= take && pop_item.emit;
        p2_valid <= p1_valid;
        out_valid <= p2_valid;
      end
    end
  end

  // Median of nine: sort each row, then the max of the minima, the median
  // of the medians and the min of the maxima; their median is the answer.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p1_rows[k] <= sort3(shifted[k*3], shifted[k*3+1], shifted[k*3+2]);
      end
      p1_col <= pop_item.col;
      p1_row <= pop_item.row;
      p1_last <= pop_item.last;

      p2_lo <= max8(max8(p1_rows[0].lo, p1_rows[1].lo), p1_rows[2].lo);
      p2_md <= md_trio.md;
      p2_hi <= min8(min8(p1_rows[0].hi, p1_rows[1].hi), p1_rows[2].hi);
      p2_col <= p1_col;
      p2_row <= p1_row;
      p2_last <= p1_last;

      median <= fin_trio.md;
      center_col <= p2_col;
      center_row <= p2_row;
      frame_last <= p2_last;
    end
  end

endmodule

/* sv/median_filter_3x3.sv */
// Channel  Handshake             Payload
// in       in_valid / in_ready   intensity, frame_start
// out      out_valid / out_ready median, center_col, center_row, frame_last
// cfg      cfg_write             cfg_index, cfg_data
//
// One pixel per clock is accepted while in_ready is high; the line stores
// give one read and one write-back per cycle, which sets that rate. A result
// passes the front stage, the queue and the p1, p2 and output registers.
// Reset clears position, window and pipeline; line stores keep their contents.
// A stalled output freezes the filter end, a four-item queue absorbs the
// backlog, and in_ready drops once it is full.
module median_filter_3x3 #(
  parameter int MAX_LINE = mf3_pkg::MF3_MAX_LINE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mf3_pkg::PIX_W-1:0]  intensity,
  input  logic                       frame_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mf3_pkg::PIX_W-1:0]  median,
  output logic [mf3_pkg::POS_W-1:0]  center_col,
  output logic [mf3_pkg::POS_W-1:0]  center_row,
  output logic                       frame_last,
  input  logic                       cfg_write,
  input  logic [0:0]                 cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]  cfg_data
);
  import mf3_pkg::*;

  localparam int LIM = (MAX_LINE < 1024) ? MAX_LINE : 1024;
  localparam logic [CFG_W-1:0] WIDTH_LIM = CFG_W'(LIM);
  localparam logic [CFG_W-1:0] HEIGHT_LIM = CFG_W'(MF3_MAX_HEIGHT);

  // The registers keep the clamped geometry, as nothing reads them back.
  logic [CFG_W-1:0] line_length, line_count;

  logic       push_valid, push_ready, pop_valid, pop_ready;
  mf3_item_t  push_item, pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= clamp_dim(LINE_LENGTH_RESET, WIDTH_LIM);
      line_count <= clamp_dim(LINE_COUNT_RESET, HEIGHT_LIM);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LINE_LENGTH: line_length <= clamp_dim(cfg_data, WIDTH_LIM);
        REG_LINE_COUNT:  line_count <= clamp_dim(cfg_data, HEIGHT_LIM);
        default: ;
      endcase
    end
  end

  mf3_front #(.MAX_LINE(MAX_LINE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .intensity  (intensity),
    .frame_start(frame_start),
    .width      (line_length),
    .height     (line_count),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  mf3_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  mf3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .median    (median),
    .center_col(center_col),
    .center_row(center_row),
    .frame_last(frame_last)
  );

endmodule

/* sv/mf3_checker.sv */
module mf3_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mf3_pkg::PIX_W-1:0]  median,
  input logic [mf3_pkg::POS_W-1:0]  center_col,
  input logic [mf3_pkg::POS_W-1:0]  center_row,
  input logic                       frame_last
);

  // A held result keeps its payload until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(median) &&
      $stable(center_col) && $stable(center_row) && $stable(frame_last))
    else $error("result changed while stalled");

  // An empty block after reset shows no result and takes input at once.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // Only interior pixels are filtered.
  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> center_col != 10'd0 && center_row != 10'd0 &&
      center_col != 10'd1023 && center_row != 10'd1023)
    else $error("result for a border pixel");

  // Handshake signals are always known once out of reset.
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({in_valid, in_ready, out_valid, out_ready}))
    else $error("unknown handshake signal");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (.*);
